// ----- src/fcc_pkg.sv -----
package fcc_pkg;

  localparam int WordWidth = 32;
  localparam int MantWidth = 24;
  localparam int FracBits  = 23;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef struct packed {
    logic                 operation;
    logic [WordWidth-1:0] operand_word;
  } in_beat_t;

  typedef struct packed {
    logic [WordWidth-1:0] result_word;
    logic                 range_flag;
  } out_beat_t;

  localparam logic [7:0]  ExpMask  = 8'hff;
  localparam logic [23:0] MantSign = 24'h800000;
  localparam logic [23:0] MantNorm = 24'h400000;
  localparam logic [23:0] SatPos   = 24'h7fffff;
  localparam logic [23:0] SatNeg   = 24'h800001;

endpackage

// ----- src/fcc_stream_if.sv -----
interface fcc_stream_if #(
  parameter int Width = 33
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/fcc_encode.sv -----
module fcc_encode (
  input  logic [31:0] word,
  output logic [31:0] result,
  output logic        flag
);
  logic        sign;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [23:0] mag;
  logic [23:0] m;

  always_comb begin
    sign = word[31];
    bexp = word[30:23];
    frac = word[22:0];
    mag = {1'b0, 1'b1, frac[22:1]};
    m = sign ? (24'd0 - mag) : mag;
    if (bexp == 8'd0) begin
      result = '0;
      flag = (frac != 23'd0);
    end else if (bexp == fcc_pkg::ExpMask || bexp > 8'd253) begin
      // packed exponent would exceed +127
      result = {8'h7f, sign ? fcc_pkg::SatNeg : fcc_pkg::SatPos};
      flag = 1'b1;
    end else begin
      result = {8'(bexp - 8'd126), m};
      flag = 1'b0;
    end
  end
endmodule

// ----- src/fcc_decode.sv -----
module fcc_decode (
  input  logic [31:0] word,
  output logic [31:0] result,
  output logic        flag
);
  logic [23:0] m;
  logic        sign;
  logic [23:0] mag;
  logic [4:0]  p;
  logic signed [9:0] biased;
  logic [23:0] norm;

  always_comb begin
    m = word[23:0];
    sign = m[23];
    mag = sign ? (24'd0 - m) : m;
    if (sign && mag == 24'd0) mag = fcc_pkg::MantSign;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) p = 5'(i);
    end
    biased = 10'(signed'({5'd0, p})) + 10'(signed'(word[31:24])) + 10'sd104;
    norm = mag << (5'd23 - p);
    if (m == 24'd0) begin
      result = '0;
      flag = 1'b0;
    end else if (biased <= 10'sd0) begin
      result = {sign, 31'd0};
      flag = 1'b1;
    end else if (biased >= 10'sd255) begin
      result = {sign, fcc_pkg::ExpMask, 23'd0};
      flag = 1'b1;
    end else begin
      result = {sign, biased[7:0], norm[22:0]};
      flag = 1'b0;
    end
  end
endmodule

// ----- src/float32_custom_float_converter.sv -----
// Converts IEEE single <-> packed float (8-bit signed exponent, 24-bit
// two's-complement mantissa), direction chosen per beat by operation.
// Channels: in_ch (sink) carries {operation, operand_word}; out_ch (source)
// carries {result_word, range_flag}. Beat on valid && ready.
// Result: valid in the cycle after the input beat; the conversion is
// combinational from in_ch.payload into the output register.
// Throughput: one beat per cycle while out_ch is ready; in_ch.ready follows
// out_ch.ready or an empty output register, so a stalled receiver holds the
// result and back-pressures the input with no loss.
// Reset: rst (synchronous) empties the output register; the result data is not reset.
// range_flag marks saturation, overflow to infinity, flush to zero, or NaN/infinity input.
module float32_custom_float_converter (
  input  logic         clk,
  input  logic         rst,
  fcc_stream_if.sink   in_ch,
  fcc_stream_if.source out_ch
);
  fcc_pkg::in_beat_t  in_beat;
  fcc_pkg::out_beat_t out_beat;
  fcc_pkg::out_beat_t calc;
  logic        out_valid;
  logic [31:0] enc_res, dec_res;
  logic        enc_flag, dec_flag;

  assign in_beat = in_ch.payload;
  assign in_ch.ready = !out_valid || out_ch.ready;

  fcc_encode u_enc (.word(in_beat.operand_word), .result(enc_res), .flag(enc_flag));
  fcc_decode u_dec (.word(in_beat.operand_word), .result(dec_res), .flag(dec_flag));

  always_comb begin
    if (in_beat.operation == fcc_pkg::OP_DECODE) begin
      calc.result_word = dec_res;
      calc.range_flag = dec_flag;
    end else begin
      calc.result_word = enc_res;
      calc.range_flag = enc_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) out_beat <= calc;
  end

  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_beat;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_beat))
    else $error("result lost under stall");
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> out_valid)
    else $error("accepted beat produced no result");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("stalled while empty");
endmodule
